/* rtl/ufw_pkg.sv */
// shared types, constants and codes of the union-find wall carver
`timescale 1ns / 1ps
package ufw_pkg;

  localparam int MAX_SIDE   = 63;
  localparam int ROW_STRIDE = 64;
  localparam int COORD_W    = $clog2(ROW_STRIDE);
  localparam int POS_W      = 2 * COORD_W;
  localparam int STORE_SIZE = ROW_STRIDE * ROW_STRIDE;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_DATA_W-1:0] side_t;

  localparam status_t STATUS_CARVED    = 2'd0;
  localparam status_t STATUS_CONNECTED = 2'd1;
  localparam status_t STATUS_REJECTED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 1'b1;

  localparam side_t SIDE_RESET = side_t'(MAX_SIDE);

  typedef struct packed {
    logic rd_en;
    pos_t rd_addr;
    logic wr_en;
    pos_t wr_addr;
    pos_t wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t status;
    coord_t  wall_x;
    coord_t  wall_y;
  } result_t;

  function automatic logic side_ok(side_t s);
    return (s >= side_t'(3)) && (32'(s) <= MAX_SIDE) && s[0];
  endfunction

endpackage

/* rtl/ufw_if.sv */
// channel interfaces for wall requests and carve results
`timescale 1ns / 1ps
interface ufw_in_if;
  logic            valid;
  logic            ready;
  ufw_pkg::coord_t cell_x;
  ufw_pkg::coord_t cell_y;
  logic            direction;

  modport source (output valid, output cell_x, output cell_y, output direction, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input direction, output ready);
endinterface

interface ufw_out_if;
  logic             valid;
  logic             ready;
  ufw_pkg::status_t status;
  ufw_pkg::coord_t  wall_x;
  ufw_pkg::coord_t  wall_y;

  modport source (output valid, output status, output wall_x, output wall_y, input ready);
  modport sink   (input valid, input status, input wall_x, input wall_y, output ready);
endinterface

/* rtl/ufw_parent_mem.sv */
// parent store memory with a clearing pass after reset
`timescale 1ns / 1ps
module ufw_parent_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufw_pkg::mem_req_t req_i,
  output ufw_pkg::pos_t     rd_data_o,
  output logic              clear_done_o
);
  import ufw_pkg::*;

  pos_t mem_q [STORE_SIZE];
  pos_t rd_data_q;
  logic clr_busy_q, clr_busy_d;
  pos_t clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + pos_t'(1);
      if (clr_cnt_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= clr_cnt_q;
    end else if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_done_o = !clr_busy_q;

endmodule

/* rtl/ufw_seq.sv */
// sequencer that walks both parent chains, compresses them and joins the roots
`timescale 1ns / 1ps
module ufw_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  ufw_pkg::coord_t   cell_x_i,
  input  ufw_pkg::coord_t   cell_y_i,
  input  logic              direction_i,
  input  ufw_pkg::side_t    maze_width_i,
  input  ufw_pkg::side_t    maze_height_i,
  input  ufw_pkg::pos_t     rd_data_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output ufw_pkg::mem_req_t req_o,
  output logic              out_load_o,
  output ufw_pkg::result_t  res_o
);
  import ufw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_CSTART = 3'd2;
  localparam logic [2:0] S_COMP   = 3'd3;
  localparam logic [2:0] S_NEXT   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  pos_t       cur_q, cur_d;
  pos_t       root_q, root_d;
  pos_t       r1_q, r1_d;
  pos_t       pos_a_q, pos_a_d;
  pos_t       pos_b_q, pos_b_d;
  logic       second_q, second_d;
  result_t    res_q, res_d;

  logic [COORD_W:0] nx, ny;
  logic             ok;
  pos_t             pos_a_in, pos_b_in;
  coord_t           wx, wy;

  always_comb begin
    nx = direction_i ? {1'b0, cell_x_i} : {1'b0, cell_x_i} + (COORD_W+1)'(2);
    ny = direction_i ? {1'b0, cell_y_i} + (COORD_W+1)'(2) : {1'b0, cell_y_i};
    ok = side_ok(maze_width_i) && side_ok(maze_height_i) && cell_x_i[0] && cell_y_i[0]
         && (nx < {1'b0, maze_width_i}) && (ny < {1'b0, maze_height_i});
    pos_a_in = {cell_y_i, cell_x_i};
    pos_b_in = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
    wx = direction_i ? cell_x_i : cell_x_i + coord_t'(1);
    wy = direction_i ? cell_y_i + coord_t'(1) : cell_y_i;
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    root_d     = root_q;
    r1_d       = r1_q;
    pos_a_d    = pos_a_q;
    pos_b_d    = pos_b_q;
    second_d   = second_q;
    res_d      = res_q;
    req_o      = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          if (!ok) begin
            res_d   = '{status: STATUS_REJECTED, wall_x: '0, wall_y: '0};
            state_d = S_DONE;
          end else begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = pos_a_in;
            cur_d         = pos_a_in;
            pos_a_d       = pos_a_in;
            pos_b_d       = pos_b_in;
            second_d      = 1'b0;
            res_d         = '{status: STATUS_CONNECTED, wall_x: wx, wall_y: wy};
            state_d       = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (rd_data_i == cur_q) begin
          root_d  = cur_q;
          cur_d   = second_q ? pos_b_q : pos_a_q;
          state_d = S_CSTART;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = rd_data_i;
          cur_d         = rd_data_i;
        end
      end
      S_CSTART: begin
        if (cur_q == root_q) begin
          state_d = S_NEXT;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = cur_q;
          state_d       = S_COMP;
        end
      end
      S_COMP: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = cur_q;
        req_o.wr_data = root_q;
        if (rd_data_i == root_q) begin
          state_d = S_NEXT;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = rd_data_i;
          cur_d         = rd_data_i;
        end
      end
      S_NEXT: begin
        if (!second_q) begin
          r1_d          = root_q;
          second_d      = 1'b1;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = pos_b_q;
          cur_d         = pos_b_q;
          state_d       = S_FIND;
        end else begin
          if (r1_q != root_q) begin
            req_o.wr_en   = 1'b1;
            req_o.wr_addr = root_q;
            req_o.wr_data = r1_q;
            res_d.status  = STATUS_CARVED;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    root_q  <= root_d;
    r1_q    <= r1_d;
    pos_a_q <= pos_a_d;
    pos_b_q <= pos_b_d;
    res_q   <= res_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign res_o  = res_q;

endmodule

/* rtl/union_find_wall_carver_core.sv */
// top level of the union-find wall carver: config registers, output register, wiring
//
// Takes one wall request at a time and returns one result beat for it. After reset the
// parent store is cleared in a pass over its 4096 entries (one entry per cycle), during
// which no request is taken; config writes are taken at all times. A rejected request
// goes from the idle state straight to the done state and from there into the output
// register. An accepted request walks the first parent chain to its root, rewrites that
// chain to point at the root, does the same for the second chain and then joins the two
// roots if they differ, all through the one read port and one write port of the parent
// memory. A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module union_find_wall_carver_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ufw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ufw_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  ufw_in_if.sink                               in_i,
  ufw_out_if.source                            out_o
);
  import ufw_pkg::*;

  side_t    maze_width_q, maze_height_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_res_q;
  mem_req_t mem_req;
  pos_t     mem_rd_data;
  logic     clear_done;
  logic     seq_idle;
  logic     in_fire;
  logic     out_free;
  logic     out_load;
  result_t  seq_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maze_width_q  <= SIDE_RESET;
      maze_height_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAZE_WIDTH:  maze_width_q  <= cfg_data_i;
        CFG_MAZE_HEIGHT: maze_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = seq_idle && clear_done;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  ufw_parent_mem u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (mem_req),
    .rd_data_o    (mem_rd_data),
    .clear_done_o (clear_done)
  );

  ufw_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .cell_x_i      (in_i.cell_x),
    .cell_y_i      (in_i.cell_y),
    .direction_i   (in_i.direction),
    .maze_width_i  (maze_width_q),
    .maze_height_i (maze_height_q),
    .rd_data_i     (mem_rd_data),
    .out_free_i    (out_free),
    .idle_o        (seq_idle),
    .req_o         (mem_req),
    .out_load_o    (out_load),
    .res_o         (seq_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= seq_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_res_q.status;
  assign out_o.wall_x = out_res_q.wall_x;
  assign out_o.wall_y = out_res_q.wall_y;

endmodule

/* bench/union_find_wall_carver_core_tb.sv */
// self-checking testbench of the union-find wall carver: directed table, then random phases
`timescale 1ns / 1ps
module union_find_wall_carver_core_tb;
  import ufw_pkg::*;

  localparam int NUM_GRIDS = 14;
  localparam int NUM_ROWS  = 20;
  localparam int IDLE_PCT  = 31;
  localparam int HOLD_AT   = 250;
  localparam int HOLD_LEN  = 300;

  typedef struct {
    coord_t  x;
    coord_t  y;
    logic    down;
    bit      typed;
    status_t st;
    coord_t  wx;
    coord_t  wy;
  } wall_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  side_t                cfg_data_i;

  ufw_in_if  req ();
  ufw_out_if rsp ();

  union_find_wall_carver_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req),
    .out_o      (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset grid is 63 x 63; typed rows are plain to see, the rest go through the predictor
  wall_row_t plan [NUM_ROWS] = '{
    '{6'd1,  6'd1,  1'b0, 1'b1, STATUS_CARVED,    6'd2,  6'd1},
    '{6'd1,  6'd1,  1'b0, 1'b1, STATUS_CONNECTED, 6'd2,  6'd1},
    '{6'd1,  6'd1,  1'b1, 1'b1, STATUS_CARVED,    6'd1,  6'd2},
    '{6'd3,  6'd1,  1'b1, 1'b1, STATUS_CARVED,    6'd3,  6'd2},
    '{6'd1,  6'd3,  1'b0, 1'b0, STATUS_CARVED,    6'd0,  6'd0},
    '{6'd61, 6'd61, 1'b0, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd61, 6'd61, 1'b1, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd59, 6'd61, 1'b0, 1'b1, STATUS_CARVED,    6'd60, 6'd61},
    '{6'd61, 6'd59, 1'b1, 1'b1, STATUS_CARVED,    6'd61, 6'd60},
    '{6'd0,  6'd1,  1'b0, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd1,  6'd0,  1'b1, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd63, 6'd63, 1'b0, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd63, 6'd1,  1'b1, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd62, 6'd62, 1'b1, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd2,  6'd2,  1'b0, 1'b1, STATUS_REJECTED,  6'd0,  6'd0},
    '{6'd61, 6'd1,  1'b1, 1'b1, STATUS_CARVED,    6'd61, 6'd2},
    '{6'd1,  6'd61, 1'b0, 1'b1, STATUS_CARVED,    6'd2,  6'd61},
    '{6'd59, 6'd59, 1'b0, 1'b0, STATUS_CARVED,    6'd0,  6'd0},
    '{6'd59, 6'd59, 1'b1, 1'b0, STATUS_CARVED,    6'd0,  6'd0},
    '{6'd61, 6'd1,  1'b0, 1'b1, STATUS_REJECTED,  6'd0,  6'd0}
  };

  side_t grid_w_list [NUM_GRIDS] = '{
    6'd7, 6'd3, 6'd15, 6'd62, 6'd31, 6'd63, 6'd5, 6'd63, 6'd3, 6'd0, 6'd11, 6'd9, 6'd2, 6'd63
  };
  side_t grid_h_list [NUM_GRIDS] = '{
    6'd7, 6'd3, 6'd9, 6'd63, 6'd31, 6'd1, 6'd5, 6'd3, 6'd63, 6'd2, 6'd13, 6'd5, 6'd63, 6'd63
  };

  pos_t    parent_of [STORE_SIZE];
  side_t   grid_w;
  side_t   grid_h;
  result_t pending_walls [$];
  bit      calm;
  int      errors;
  int      results_seen;
  int      n_sent;
  int      n_carved;
  int      n_joined;
  int      n_refused;
  int      held_cycles;

  task automatic flag_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40) $display("%0t ns mismatch in %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic pos_t find_root(pos_t p);
    pos_t r;
    pos_t walk;
    pos_t nxt;
    r = p;
    while (parent_of[r] != r) r = parent_of[r];
    walk = p;
    while (walk != r) begin
      nxt = parent_of[walk];
      parent_of[walk] = r;
      walk = nxt;
    end
    return r;
  endfunction

  function automatic result_t carve_wall(coord_t x, coord_t y, logic down);
    int      nx;
    int      ny;
    bit      grid_ok;
    pos_t    ra;
    pos_t    rb;
    result_t res;
    nx = down ? int'(x) : int'(x) + 2;
    ny = down ? int'(y) + 2 : int'(y);
    grid_ok = grid_w >= 3 && int'(grid_w) <= MAX_SIDE && grid_w[0]
              && grid_h >= 3 && int'(grid_h) <= MAX_SIDE && grid_h[0];
    res.status = STATUS_REJECTED;
    res.wall_x = '0;
    res.wall_y = '0;
    if (grid_ok && x[0] && y[0] && nx < int'(grid_w) && ny < int'(grid_h)) begin
      ra = find_root(pos_t'(int'(y) * ROW_STRIDE + int'(x)));
      rb = find_root(pos_t'(ny * ROW_STRIDE + nx));
      res.status = STATUS_CONNECTED;
      if (ra != rb) begin
        parent_of[rb] = ra;
        res.status = STATUS_CARVED;
      end
      res.wall_x = down ? x : coord_t'(x + 1);
      res.wall_y = down ? coord_t'(y + 1) : y;
    end
    return res;
  endfunction

  // offers one request and returns at the edge where it is taken; valid stays high
  task automatic push_request(coord_t x, coord_t y, logic down);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.cell_x    <= x;
    req.cell_y    <= y;
    req.direction <= down;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic note_result(result_t r);
    pending_walls.insert(pending_walls.size(), r);
    case (r.status)
      STATUS_CARVED:    n_carved++;
      STATUS_CONNECTED: n_joined++;
      default:          n_refused++;
    endcase
  endtask

  task automatic set_grid(side_t w, side_t h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAZE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAZE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_w = w;
    grid_h = h;
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_walls.size() != 0) @(posedge clk_i);
  endtask

  // sink side: random back-pressure plus one long hold-off to fill the block
  initial begin : sink_side
    int unsigned k;
    bit          held;
    held = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        for (k = 0; k < HOLD_LEN; k++) @(posedge clk_i);
        held_cycles = HOLD_LEN;
      end
      rsp.ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_walls.size() == 0) begin
        flag_mismatch("unrequested beat, status", rsp.status, -1);
      end else begin
        want = pending_walls.pop_front();
        if (rsp.status !== want.status) flag_mismatch("status", rsp.status, want.status);
        if (rsp.wall_x !== want.wall_x) flag_mismatch("wall_x", rsp.wall_x, want.wall_x);
        if (rsp.wall_y !== want.wall_y) flag_mismatch("wall_y", rsp.wall_y, want.wall_y);
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("union_find_wall_carver_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int      g;
    int      k;
    int      n_items;
    int      kx;
    int      ky;
    bit      walls_possible;
    coord_t  x;
    coord_t  y;
    logic    down;
    result_t r;

    errors       = 0;
    results_seen = 0;
    n_sent       = 0;
    n_carved     = 0;
    n_joined     = 0;
    n_refused    = 0;
    held_cycles  = 0;
    calm         = 1'b0;
    grid_w       = SIDE_RESET;
    grid_h       = SIDE_RESET;
    for (int i = 0; i < STORE_SIZE; i++) parent_of[i] = pos_t'(i);

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MAZE_WIDTH;
    cfg_data_i    <= '0;
    req.valid     <= 1'b0;
    req.cell_x    <= '0;
    req.cell_y    <= '0;
    req.direction <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      push_request(plan[i].x, plan[i].y, plan[i].down);
      r = carve_wall(plan[i].x, plan[i].y, plan[i].down);
      if (plan[i].typed) begin
        r.status = plan[i].st;
        r.wall_x = plan[i].wx;
        r.wall_y = plan[i].wy;
      end
      note_result(r);
    end

    for (g = 0; g < NUM_GRIDS; g++) begin
      drain_results();
      set_grid(grid_w_list[g], grid_h_list[g]);
      calm = (g == 4);
      walls_possible = grid_w >= 3 && grid_w[0] && grid_h >= 3 && grid_h[0]
                       && (grid_w >= 5 || grid_h >= 5);
      n_items = walls_possible ? 170 : 20;
      for (k = 0; k < n_items; k++) begin
        if (!walls_possible || $urandom_range(99) < 15) begin
          x    = coord_t'($urandom_range(63));
          y    = coord_t'($urandom_range(63));
          down = 1'($urandom_range(1));
          if ($urandom_range(1)) begin
            x[0] = 1'b1;
            y[0] = 1'b1;
          end
        end else begin
          if (grid_w < 5)      down = 1'b1;
          else if (grid_h < 5) down = 1'b0;
          else                 down = 1'($urandom_range(1));
          kx = down ? (int'(grid_w) - 3) / 2 : (int'(grid_w) - 5) / 2;
          ky = down ? (int'(grid_h) - 5) / 2 : (int'(grid_h) - 3) / 2;
          x  = coord_t'(2 * $urandom_range(kx, 0) + 1);
          y  = coord_t'(2 * $urandom_range(ky, 0) + 1);
        end
        push_request(x, y, down);
        note_result(carve_wall(x, y, down));
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (16) @(posedge clk_i);

    $display("%0d wall requests over %0d grid settings: %0d carved, %0d already joined, %0d refused",
             n_sent, NUM_GRIDS + 1, n_carved, n_joined, n_refused);
    $display("%0d result beats checked, one sink hold-off of %0d cycles, %0d mismatches",
             results_seen, held_cycles, errors);
    if (errors == 0 && pending_walls.size() == 0) begin
      $display("union_find_wall_carver_core_tb: clean");
    end else begin
      $display("union_find_wall_carver_core_tb: errors");
    end
    $finish;
  end

endmodule
